/* src/asmlt_pkg.sv */
package asmlt_pkg;

    localparam int LINE_LEN_DEF  = 256;
    localparam int ARG_SLOTS_DEF = 4;

    localparam int CHAR_W  = 8;
    localparam int OFF_W   = 9;
    localparam int CNT_W   = 9;
    localparam int IDX_W   = 3;
    localparam int KIND_W  = 2;
    localparam int ERR_W   = 2;

    localparam logic [CHAR_W-1:0] COMMENT_RESET = 8'd35;
    localparam logic [CHAR_W-1:0] COMMA_CODE    = 8'd44;
    localparam logic [CNT_W-1:0]  CNT_MAX       = '1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_MNEM = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ARG  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STAT = 2'd2;

    // line status codes
    localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_SYNTAX = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LONG   = 2'd2;

    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              is_end;
    } asmlt_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  arg_index;
        logic [OFF_W-1:0]  start_off;
        logic [OFF_W-1:0]  end_off;
        logic [CNT_W-1:0]  arg_count;
        logic [ERR_W-1:0]  error_code;
        logic              last_of_run;
    } asmlt_res_t;

    // Everything one request produces: an optional token, then an optional status.
    typedef struct packed {
        logic              tok_valid;
        logic [KIND_W-1:0] tok_kind;
        logic [IDX_W-1:0]  tok_idx;
        logic [OFF_W-1:0]  tok_so;
        logic [OFF_W-1:0]  tok_eo;
        logic              stat_valid;
        logic [CNT_W-1:0]  stat_cnt;
        logic [ERR_W-1:0]  stat_err;
    } asmlt_outcome_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

endpackage

/* src/asmlt_parser.sv */
module asmlt_parser #(
    parameter int LINE_LEN  = asmlt_pkg::LINE_LEN_DEF,
    parameter int ARG_SLOTS = asmlt_pkg::ARG_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           take,
    input  asmlt_pkg::asmlt_req_t          req,
    input  logic [asmlt_pkg::CHAR_W-1:0]   comment_char,
    output asmlt_pkg::asmlt_outcome_t      outcome
);

    localparam int PW = $clog2(LINE_LEN + 1);
    localparam int OW = asmlt_pkg::OFF_W;

    localparam logic [2:0] PH_LEAD        = 3'd0;
    localparam logic [2:0] PH_MNEM        = 3'd1;
    localparam logic [2:0] PH_AFTER_MNEM  = 3'd2;
    localparam logic [2:0] PH_ARG         = 3'd3;
    localparam logic [2:0] PH_AFTER_ARG   = 3'd4;
    localparam logic [2:0] PH_AFTER_COMMA = 3'd5;
    localparam logic [2:0] PH_COMMA_WS    = 3'd6;
    localparam logic [2:0] PH_DONE        = 3'd7;

    logic [2:0]                    phase_reg, phase_next;
    logic [PW-1:0]                 pos_reg, pos_next;
    logic [PW-1:0]                 tstart_reg, tstart_next;
    logic [asmlt_pkg::CNT_W-1:0]   argcnt_reg, argcnt_next, argcnt_after;
    logic [asmlt_pkg::ERR_W-1:0]   err_reg, err_next;

    logic          close_now, mnem_emit, arg_emit;
    logic [PW-1:0] tok_so, tok_eo;
    logic          ws, comma;

    function automatic logic [OW-1:0] to_off(input logic [PW-1:0] v);
        logic [PW+OW-1:0] w;
        w = {{OW{1'b0}}, v};
        return w[OW-1:0];
    endfunction

    assign ws    = asmlt_pkg::is_space(req.char_byte);
    assign comma = (req.char_byte == asmlt_pkg::COMMA_CODE);

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        err_next    = err_reg;
        close_now   = 1'b0;
        mnem_emit   = 1'b0;
        arg_emit    = 1'b0;
        tok_so      = pos_reg;
        tok_eo      = pos_reg;
        outcome     = '0;

        if (take) begin
            if (req.is_end) begin
                close_now = (phase_reg != PH_DONE);
            end else if (pos_reg >= PW'(LINE_LEN)) begin
                if (err_reg == asmlt_pkg::ERR_NONE) begin
                    err_next = asmlt_pkg::ERR_LONG;
                end
                phase_next = PH_DONE;
            end else begin
                pos_next = pos_reg + 1'b1;
                if (phase_reg != PH_DONE) begin
                    if ((req.char_byte == comment_char) || (req.char_byte == '0)) begin
                        close_now = 1'b1;
                    end else begin
                        case (phase_reg)
                            PH_LEAD: begin
                                if (comma) begin
                                    mnem_emit  = 1'b1;
                                    err_next   = asmlt_pkg::ERR_SYNTAX;
                                    phase_next = PH_DONE;
                                end else if (!ws) begin
                                    tstart_next = pos_reg;
                                    phase_next  = PH_MNEM;
                                end
                            end
                            PH_MNEM: begin
                                if (ws || comma) begin
                                    mnem_emit = 1'b1;
                                    tok_so    = tstart_reg;
                                    if (comma) begin
                                        err_next   = asmlt_pkg::ERR_SYNTAX;
                                        phase_next = PH_DONE;
                                    end else begin
                                        phase_next = PH_AFTER_MNEM;
                                    end
                                end
                            end
                            PH_AFTER_MNEM: begin
                                if (comma) begin
                                    err_next   = asmlt_pkg::ERR_SYNTAX;
                                    phase_next = PH_DONE;
                                end else if (!ws) begin
                                    tstart_next = pos_reg;
                                    phase_next  = PH_ARG;
                                end
                            end
                            PH_ARG: begin
                                if (ws || comma) begin
                                    arg_emit   = 1'b1;
                                    tok_so     = tstart_reg;
                                    phase_next = comma ? PH_AFTER_COMMA : PH_AFTER_ARG;
                                end
                            end
                            PH_AFTER_ARG: begin
                                if (comma) begin
                                    phase_next = PH_AFTER_COMMA;
                                end else if (!ws) begin
                                    err_next   = asmlt_pkg::ERR_SYNTAX;
                                    phase_next = PH_DONE;
                                end
                            end
                            PH_AFTER_COMMA, PH_COMMA_WS: begin
                                if (comma) begin
                                    arg_emit   = 1'b1;
                                    phase_next = PH_AFTER_COMMA;
                                end else if (ws) begin
                                    phase_next = PH_COMMA_WS;
                                end else begin
                                    tstart_next = pos_reg;
                                    phase_next  = PH_ARG;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
        end

        // content closed by comment, NUL or end of line: flush the pending token
        if (close_now) begin
            phase_next = PH_DONE;
            case (phase_reg)
                PH_LEAD: mnem_emit = 1'b1;
                PH_MNEM: begin
                    mnem_emit = 1'b1;
                    tok_so    = tstart_reg;
                end
                PH_ARG: begin
                    arg_emit = 1'b1;
                    tok_so   = tstart_reg;
                end
                PH_COMMA_WS: arg_emit = 1'b1;
                default: begin
                end
            endcase
        end

        if (mnem_emit) begin
            outcome.tok_valid = 1'b1;
            outcome.tok_kind  = asmlt_pkg::KIND_MNEM;
            outcome.tok_so    = to_off(tok_so);
            outcome.tok_eo    = to_off(tok_eo);
        end
        if (arg_emit && (argcnt_reg < asmlt_pkg::CNT_W'(ARG_SLOTS))) begin
            outcome.tok_valid = 1'b1;
            outcome.tok_kind  = asmlt_pkg::KIND_ARG;
            outcome.tok_idx   = argcnt_reg[asmlt_pkg::IDX_W-1:0];
            outcome.tok_so    = to_off(tok_so);
            outcome.tok_eo    = to_off(tok_eo);
        end

        argcnt_after = argcnt_reg;
        if (arg_emit && (argcnt_reg != asmlt_pkg::CNT_MAX)) begin
            argcnt_after = argcnt_reg + 1'b1;
        end
        argcnt_next = argcnt_after;

        if (take && req.is_end) begin
            outcome.stat_valid = 1'b1;
            outcome.stat_err   = err_reg;
            outcome.stat_cnt   = (err_reg != asmlt_pkg::ERR_NONE) ? '0 : argcnt_after;
            phase_next  = PH_LEAD;
            pos_next    = '0;
            tstart_next = '0;
            argcnt_next = '0;
            err_next    = asmlt_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LEAD;
            pos_reg    <= '0;
            tstart_reg <= '0;
            argcnt_reg <= '0;
            err_reg    <= asmlt_pkg::ERR_NONE;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            argcnt_reg <= argcnt_next;
            err_reg    <= err_next;
        end
    end

endmodule

/* src/asm_line_tokenizer_unit.sv */
// Assembly line tokenizer. Characters of one line arrive one per request on the
// s_ channel; a request with is_end set closes the line. The unit takes one request
// per cycle while the queue has room: the phase machine updates its state and works
// out the results of that request in the same cycle, and they land in a two-entry
// result queue, so a new request is taken while earlier results wait on m_ready. A
// request gives at most one result, except an end request, which gives the flushed
// token (if one was pending) and then the line status, so the output side, at one
// result per cycle while m_ready is high, sets the rate on such lines. For each line
// the unit reports the mnemonic (offsets of first and past-last character; empty
// at the content end if there is none), then each comma-separated argument (empty
// ones included), only the first ARG_SLOTS of them but all counted, and finally a
// status with the argument count and error code: syntax error for a comma right
// after the mnemonic or two arguments split only by whitespace, line too long once
// more than LINE_LEN characters arrive. The count reads 0 on any error. The comment
// character (cfg_wr_data, reset '#') or a NUL byte ends the line content; write it
// only while the unit is idle. last_of_run marks the last result of each request.
module asm_line_tokenizer_unit #(
    parameter int LINE_LEN  = asmlt_pkg::LINE_LEN_DEF,
    parameter int ARG_SLOTS = asmlt_pkg::ARG_SLOTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  asmlt_pkg::asmlt_req_t        s_payload,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output asmlt_pkg::asmlt_res_t        m_payload,
    // comment character register
    input  logic                         cfg_wr_en,
    input  logic [asmlt_pkg::CHAR_W-1:0] cfg_wr_data
);

    logic [asmlt_pkg::CHAR_W-1:0] comment_char_reg;

    asmlt_pkg::asmlt_outcome_t outcome;
    asmlt_pkg::asmlt_outcome_t queue_reg [2];
    asmlt_pkg::asmlt_outcome_t head;

    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       sub_reg;      // token of the head entry already sent, status next
    logic       take, push, pop, show_tok;

    assign s_ready = (count_reg != 2'd2);
    assign take    = s_valid && s_ready;
    assign push    = take && (outcome.tok_valid || outcome.stat_valid);

    // comment character; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comment_char_reg <= asmlt_pkg::COMMENT_RESET;
        end else if (cfg_wr_en) begin
            comment_char_reg <= cfg_wr_data;
        end
    end

    asmlt_parser #(
        .LINE_LEN  (LINE_LEN),
        .ARG_SLOTS (ARG_SLOTS)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .req          (s_payload),
        .comment_char (comment_char_reg),
        .outcome      (outcome)
    );

    // ---- result queue and serialiser ----
    assign head     = queue_reg[rd_ptr_reg];
    assign m_valid  = (count_reg != 2'd0);
    assign show_tok = head.tok_valid && !sub_reg;

    always_comb begin
        m_payload = '0;
        if (show_tok) begin
            m_payload.kind        = head.tok_kind;
            m_payload.arg_index   = head.tok_idx;
            m_payload.start_off   = head.tok_so;
            m_payload.end_off     = head.tok_eo;
            m_payload.last_of_run = !head.stat_valid;
        end else begin
            m_payload.kind        = asmlt_pkg::KIND_STAT;
            m_payload.arg_count   = head.stat_cnt;
            m_payload.error_code  = head.stat_err;
            m_payload.last_of_run = 1'b1;
        end
    end

    // an entry leaves once its last result is taken
    assign pop = m_valid && m_ready && (!show_tok || !head.stat_valid);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= outcome;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
                sub_reg    <= 1'b0;
            end else if (m_valid && m_ready && show_tok) begin
                sub_reg <= 1'b1;
            end
        end
    end

    // ---- assertions ----
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_payload.last_of_run
        |=> m_valid && (m_payload.kind == asmlt_pkg::KIND_STAT))
        else $error("token not followed by its line status");

    a_sub_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg |-> m_valid && head.tok_valid && head.stat_valid)
        else $error("serialiser half-way through an entry without a pair");

    a_token_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.kind != asmlt_pkg::KIND_STAT)
        |-> (m_payload.arg_count == '0) && (m_payload.error_code == asmlt_pkg::ERR_NONE))
        else $error("token carries status fields");

    a_err_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.kind == asmlt_pkg::KIND_STAT)
        && (m_payload.error_code != asmlt_pkg::ERR_NONE)
        |-> (m_payload.arg_count == '0))
        else $error("argument count reported on a failed line");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |=> !(count_reg == 2'd0) && (count_reg != 2'd3))
        else $error("result queue count out of range");

endmodule

/* bench/asm_line_tokenizer_unit_tb.sv */
module asm_line_tokenizer_unit_tb;

    localparam int LINE_LEN        = asmlt_pkg::LINE_LEN_DEF;
    localparam int ARG_SLOTS       = asmlt_pkg::ARG_SLOTS_DEF;
    localparam int ITEM_BUDGET     = 750;
    localparam int N_PHASES        = 6;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int SETTLE_CYCLES   = 6;
    localparam int DRAIN_LIMIT     = 5000;

    // Comment character per random phase: both extremes, a comma, a blank,
    // a random code (slot 4, drawn at run time) and finally back to '#'.
    localparam logic [asmlt_pkg::CHAR_W-1:0] COMMENT_PLAN [N_PHASES] =
        '{8'd0, 8'd255, asmlt_pkg::COMMA_CODE, 8'd32, 8'd0, asmlt_pkg::COMMENT_RESET};

    // Where the tokenizer stands within the current line.
    typedef enum logic [3:0] {
        LX_LEAD,         // nothing but blanks so far
        LX_MNEM,         // inside the mnemonic
        LX_POST_MNEM,    // blanks after the mnemonic
        LX_OPERAND,      // inside an argument
        LX_POST_OPERAND, // blanks after an argument
        LX_POST_COMMA,   // straight after a comma
        LX_COMMA_BLANK,  // blanks after a comma
        LX_CLOSED        // content over: comment, NUL, syntax error or overflow
    } lex_phase_t;

    // One row of the directed script. Where n_fixed is non-zero the results are
    // written out by hand and stand in for the predictor's.
    typedef struct packed {
        asmlt_pkg::asmlt_req_t req;
        logic [1:0]            n_fixed;
        asmlt_pkg::asmlt_res_t fix_a;
        asmlt_pkg::asmlt_res_t fix_b;
    } script_row_t;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    asmlt_pkg::asmlt_req_t        s_payload   = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    asmlt_pkg::asmlt_res_t        m_payload;
    logic                         cfg_wr_en   = 1'b0;
    logic [asmlt_pkg::CHAR_W-1:0] cfg_wr_data = '0;

    initial begin : clock_gen
        forever #6 aclk = ~aclk;
    end

    asm_line_tokenizer_unit #(
        .LINE_LEN (LINE_LEN),
        .ARG_SLOTS(ARG_SLOTS)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    asmlt_pkg::asmlt_res_t pending_results [$];  // expected, oldest first
    asmlt_pkg::asmlt_res_t step_results [$];     // what the last request produced
    asmlt_pkg::asmlt_req_t line_buf [$];         // the line being sent
    script_row_t           script [$];

    int   mismatches   = 0;
    int   n_requests   = 0;
    int   n_lines      = 0;
    int   n_checked    = 0;
    logic tx_burst     = 1'b0;        // sender offers back to back when set
    logic hold_off_req = 1'b0;        // asks the receiver for one long stall

    // ------------------------------------------------------------------
    // Predictor: a private copy of the line state and the comment register.
    // ------------------------------------------------------------------
    logic [asmlt_pkg::CHAR_W-1:0] cmt_char;
    lex_phase_t                   lx_phase;
    int                           lx_pos;
    int                           lx_tok_start;
    logic [asmlt_pkg::CNT_W-1:0]  lx_nargs;
    logic [asmlt_pkg::ERR_W-1:0]  lx_err;

    function automatic asmlt_pkg::asmlt_res_t res_of(logic [asmlt_pkg::KIND_W-1:0] kind,
                                                     int idx, int so, int eo, int cnt,
                                                     logic [asmlt_pkg::ERR_W-1:0] err,
                                                     logic last);
        asmlt_pkg::asmlt_res_t r;
        r.kind        = kind;
        r.arg_index   = asmlt_pkg::IDX_W'(idx);
        r.start_off   = asmlt_pkg::OFF_W'(so);
        r.end_off     = asmlt_pkg::OFF_W'(eo);
        r.arg_count   = asmlt_pkg::CNT_W'(cnt);
        r.error_code  = err;
        r.last_of_run = last;
        return r;
    endfunction

    function automatic logic blank_char(logic [asmlt_pkg::CHAR_W-1:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void clear_line();
        lx_phase     = LX_LEAD;
        lx_pos       = 0;
        lx_tok_start = 0;
        lx_nargs     = '0;
        lx_err       = asmlt_pkg::ERR_NONE;
    endfunction

    // Every argument is counted; only the first ARG_SLOTS leave as tokens.
    function automatic void count_operand(int so, int eo);
        if (lx_nargs < ARG_SLOTS)
            step_results.push_back(res_of(asmlt_pkg::KIND_ARG, lx_nargs, so, eo, 0,
                                          asmlt_pkg::ERR_NONE, 1'b0));
        if (lx_nargs != asmlt_pkg::CNT_MAX)
            lx_nargs++;
    endfunction

    // Content stops at p: flush whatever token is open.
    function automatic void end_content(int p);
        case (lx_phase)
            LX_LEAD: begin
                step_results.push_back(res_of(asmlt_pkg::KIND_MNEM, 0, p, p, 0,
                                              asmlt_pkg::ERR_NONE, 1'b0));
            end
            LX_MNEM: begin
                step_results.push_back(res_of(asmlt_pkg::KIND_MNEM, 0, lx_tok_start, p, 0,
                                              asmlt_pkg::ERR_NONE, 1'b0));
            end
            LX_OPERAND:     count_operand(lx_tok_start, p);
            LX_COMMA_BLANK: count_operand(p, p);
            default: ;
        endcase
        lx_phase = LX_CLOSED;
    endfunction

    function automatic void tokenize_char(logic [asmlt_pkg::CHAR_W-1:0] c, int p);
        logic blank;
        logic comma;
        blank = blank_char(c);
        comma = (c == asmlt_pkg::COMMA_CODE);
        if (lx_phase == LX_CLOSED)
            return;
        if (c == cmt_char || c == 8'd0) begin
            end_content(p);
            return;
        end
        case (lx_phase)
            LX_LEAD: begin
                if (comma) begin
                    step_results.push_back(res_of(asmlt_pkg::KIND_MNEM, 0, p, p, 0,
                                                  asmlt_pkg::ERR_NONE, 1'b0));
                    lx_err   = asmlt_pkg::ERR_SYNTAX;
                    lx_phase = LX_CLOSED;
                end else if (!blank) begin
                    lx_tok_start = p;
                    lx_phase     = LX_MNEM;
                end
            end
            LX_MNEM: begin
                if (blank || comma) begin
                    step_results.push_back(res_of(asmlt_pkg::KIND_MNEM, 0, lx_tok_start, p, 0,
                                                  asmlt_pkg::ERR_NONE, 1'b0));
                    if (comma) begin
                        lx_err   = asmlt_pkg::ERR_SYNTAX;
                        lx_phase = LX_CLOSED;
                    end else begin
                        lx_phase = LX_POST_MNEM;
                    end
                end
            end
            LX_POST_MNEM: begin
                if (comma) begin
                    lx_err   = asmlt_pkg::ERR_SYNTAX;
                    lx_phase = LX_CLOSED;
                end else if (!blank) begin
                    lx_tok_start = p;
                    lx_phase     = LX_OPERAND;
                end
            end
            LX_OPERAND: begin
                if (blank || comma) begin
                    count_operand(lx_tok_start, p);
                    lx_phase = comma ? LX_POST_COMMA : LX_POST_OPERAND;
                end
            end
            LX_POST_OPERAND: begin
                if (comma) begin
                    lx_phase = LX_POST_COMMA;
                end else if (!blank) begin
                    lx_err   = asmlt_pkg::ERR_SYNTAX;
                    lx_phase = LX_CLOSED;
                end
            end
            default: begin
                if (comma) begin
                    count_operand(p, p);
                    lx_phase = LX_POST_COMMA;
                end else if (blank) begin
                    lx_phase = LX_COMMA_BLANK;
                end else begin
                    lx_tok_start = p;
                    lx_phase     = LX_OPERAND;
                end
            end
        endcase
    endfunction

    // One accepted request: results land in step_results, last one flagged.
    function automatic void advance_tokenizer(asmlt_pkg::asmlt_req_t r);
        asmlt_pkg::asmlt_res_t tail;
        step_results.delete();
        if (r.is_end) begin
            if (lx_phase != LX_CLOSED)
                end_content(lx_pos);
            step_results.push_back(res_of(asmlt_pkg::KIND_STAT, 0, 0, 0,
                                          (lx_err != asmlt_pkg::ERR_NONE) ? 0 : lx_nargs,
                                          lx_err, 1'b0));
            clear_line();
        end else if (lx_pos >= LINE_LEN) begin
            if (lx_err == asmlt_pkg::ERR_NONE)
                lx_err = asmlt_pkg::ERR_LONG;
            lx_phase = LX_CLOSED;
        end else begin
            tokenize_char(r.char_byte, lx_pos);
            lx_pos++;
        end
        if (step_results.size() > 0) begin
            tail = step_results.pop_back();
            tail.last_of_run = 1'b1;
            step_results.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] ERROR %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [8:0] got, logic [8:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    // Outputs sampled at the rising edge, compared with the oldest expectation.
    always @(posedge aclk) begin : result_check
        asmlt_pkg::asmlt_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result of kind %0d with nothing pending",
                                          m_payload.kind));
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("kind",        m_payload.kind,        want.kind);
                check_field("arg_index",   m_payload.arg_index,   want.arg_index);
                check_field("start_off",   m_payload.start_off,   want.start_off);
                check_field("end_off",     m_payload.end_off,     want.end_off);
                check_field("arg_count",   m_payload.arg_count,   want.arg_count);
                check_field("error_code",  m_payload.error_code,  want.error_code);
                check_field("last_of_run", m_payload.last_of_run, want.last_of_run);
            end
        end
    end

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // Idle length: mostly short, now and then a long one.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [asmlt_pkg::CHAR_W-1:0] blank_pick();
        case ($urandom_range(0, 5))
            0:       return 8'd9;
            1:       return 8'd10;
            2:       return 8'd11;
            3:       return 8'd12;
            4:       return 8'd13;
            default: return 8'd32;
        endcase
    endfunction

    // Any code that neither separates nor truncates under the current setting.
    function automatic logic [asmlt_pkg::CHAR_W-1:0] word_char();
        logic [asmlt_pkg::CHAR_W-1:0] c;
        do
            c = asmlt_pkg::CHAR_W'($urandom_range(1, 255));
        while (blank_char(c) || c == asmlt_pkg::COMMA_CODE || c == cmt_char);
        return c;
    endfunction

    // Weighted towards the characters the phase machine reacts to.
    function automatic logic [asmlt_pkg::CHAR_W-1:0] noise_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return blank_pick();
        else if (r < 45)
            return asmlt_pkg::COMMA_CODE;
        else if (r < 50)
            return cmt_char;
        else if (r < 53)
            return 8'd0;
        return asmlt_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic void add_char(logic [asmlt_pkg::CHAR_W-1:0] c);
        line_buf.push_back('{c, 1'b0});
    endfunction

    // Builds one line plus its end request. long_len > 0 gives a clean line of
    // exactly that many characters ending inside an argument.
    function automatic void compose_line(int long_len);
        int mode;
        int n_ops;
        line_buf.delete();
        if (long_len > 0) begin
            add_char(word_char());
            add_char(8'd32);
            add_char(word_char());
            while (line_buf.size() < long_len - 1)
                add_char(($urandom_range(0, 4) == 0) ? asmlt_pkg::COMMA_CODE : word_char());
            add_char(word_char());
        end else begin
            mode = $urandom_range(0, 99);
            if (mode < 85) begin
                repeat ($urandom_range(0, 2)) add_char(blank_pick());
                repeat ($urandom_range(1, 6)) add_char(word_char());
                n_ops = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 9)
                                                    : $urandom_range(0, 4);
                for (int i = 0; i < n_ops; i++) begin
                    if (i == 0) begin
                        repeat ($urandom_range(1, 2)) add_char(blank_pick());
                    end else begin
                        add_char(asmlt_pkg::COMMA_CODE);
                        repeat ($urandom_range(0, 1)) add_char(blank_pick());
                    end
                    // later arguments are sometimes left empty
                    if (i == 0 || $urandom_range(0, 6) != 0)
                        repeat ($urandom_range(1, 4)) add_char(word_char());
                    repeat ($urandom_range(0, 1)) add_char(blank_pick());
                end
                case ($urandom_range(0, 9))
                    0: add_char(asmlt_pkg::COMMA_CODE);
                    1: begin
                        add_char(asmlt_pkg::COMMA_CODE);
                        add_char(blank_pick());
                    end
                    2: begin
                        add_char(cmt_char);
                        repeat ($urandom_range(0, 4)) add_char(noise_char());
                    end
                    default: ;
                endcase
                // some well-formed lines get broken at a random spot
                if (mode >= 70)
                    line_buf[$urandom_range(0, line_buf.size() - 1)].char_byte = noise_char();
            end else begin
                repeat ($urandom_range(0, 12)) add_char(noise_char());
            end
        end
        line_buf.push_back('{asmlt_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1});
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Called and returning at a falling edge.
    // ------------------------------------------------------------------
    task automatic offer(script_row_t row);
        int gap;
        gap = (tx_burst || $urandom_range(0, 99) < 55) ? 0 : idle_span();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= row.req;
        do
            @(posedge aclk);
        while (!s_ready);
        // request taken at this edge
        advance_tokenizer(row.req);
        if (row.n_fixed == 2'd0) begin
            foreach (step_results[k])
                pending_results.push_back(step_results[k]);
        end else begin
            pending_results.push_back(row.fix_a);
            if (row.n_fixed == 2'd2)
                pending_results.push_back(row.fix_b);
        end
        n_requests++;
        if (row.req.is_end)
            n_lines++;
        @(negedge aclk);
    endtask

    // Stop offering and let every expected result come out, then settle.
    task automatic go_quiet();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_comment_char(logic [asmlt_pkg::CHAR_W-1:0] value);
        go_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cmt_char     = value;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, back-to-back stretches, and one long
    // hold-off on request, all counted here at the falling edge.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int   stall_left;
        int   burst_left;
        int   r;
        logic take;
        stall_left = 0;
        burst_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
                burst_left   = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                take = 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                take = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                take = 1'b1;
                if (r < 10) begin
                    burst_left = $urandom_range(10, 60);
                end else if (r >= 65) begin
                    stall_left = idle_span() - 1;
                    take       = 1'b0;
                end
            end
            m_ready <= take;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int line_no;
        int long_len;

        cmt_char = asmlt_pkg::COMMENT_RESET;
        clear_line();

        // Directed script, comment character still at its reset value '#'.
        script = '{
            // straight after reset: a bare end gives an empty mnemonic at 0
            '{'{8'h00, 1'b1}, 2'd2,
              res_of(asmlt_pkg::KIND_MNEM, 0, 0, 0, 0, asmlt_pkg::ERR_NONE, 1'b0),
              res_of(asmlt_pkg::KIND_STAT, 0, 0, 0, 0, asmlt_pkg::ERR_NONE, 1'b1)},
            // "m," : comma right after the mnemonic
            '{'{8'h6D, 1'b0}, 2'd0, '0, '0},
            '{'{8'h2C, 1'b0}, 2'd1,
              res_of(asmlt_pkg::KIND_MNEM, 0, 0, 1, 0, asmlt_pkg::ERR_NONE, 1'b1), '0},
            '{'{8'hA5, 1'b1}, 2'd1,
              res_of(asmlt_pkg::KIND_STAT, 0, 0, 0, 0, asmlt_pkg::ERR_SYNTAX, 1'b1), '0},
            // 0xFF mnemonic, then two arguments split by blanks only
            '{'{8'hFF, 1'b0}, 2'd0, '0, '0},
            '{'{8'h20, 1'b0}, 2'd0, '0, '0},
            '{'{8'h61, 1'b0}, 2'd0, '0, '0},
            '{'{8'h09, 1'b0}, 2'd0, '0, '0},
            '{'{8'h62, 1'b0}, 2'd0, '0, '0},
            '{'{8'hFF, 1'b1}, 2'd1,
              res_of(asmlt_pkg::KIND_STAT, 0, 0, 0, 0, asmlt_pkg::ERR_SYNTAX, 1'b1), '0},
            // "r a,,<tab>#" : empty argument between commas, blank then comment
            '{'{8'h72, 1'b0}, 2'd0, '0, '0},
            '{'{8'h20, 1'b0}, 2'd0, '0, '0},
            '{'{8'h61, 1'b0}, 2'd0, '0, '0},
            '{'{8'h2C, 1'b0}, 2'd0, '0, '0},
            '{'{8'h2C, 1'b0}, 2'd0, '0, '0},
            '{'{8'h09, 1'b0}, 2'd0, '0, '0},
            '{'{8'h23, 1'b0}, 2'd0, '0, '0},
            '{'{8'h00, 1'b1}, 2'd0, '0, '0},
            // "s<vt>a,<nul>" : comma right at the content end, NUL truncates
            '{'{8'h73, 1'b0}, 2'd0, '0, '0},
            '{'{8'h0B, 1'b0}, 2'd0, '0, '0},
            '{'{8'h61, 1'b0}, 2'd0, '0, '0},
            '{'{8'h2C, 1'b0}, 2'd0, '0, '0},
            '{'{8'h00, 1'b0}, 2'd0, '0, '0},
            '{'{8'h3C, 1'b1}, 2'd0, '0, '0}
        };

        // Synchronous reset, released at a falling edge.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[k])
            offer(script[k]);

        // Random lines, one comment setting per phase. The request budget is
        // shared out over the phases; each phase sends at least two lines.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_comment_char((ph == 4) ? asmlt_pkg::CHAR_W'($urandom_range(0, 255))
                                         : COMMENT_PLAN[ph]);
            // third phase opens with the receiver stalled while we keep sending
            if (ph == 2)
                hold_off_req = 1'b1;
            line_no = 0;
            while (line_no < 2 || n_requests < (ph + 1) * ITEM_BUDGET / N_PHASES) begin
                tx_burst = (ph == 2 && line_no < 6) || ($urandom_range(0, 3) == 0);
                // a line of exactly LINE_LEN characters, and one that overflows
                long_len = 0;
                if (ph == 1 && line_no == 0)
                    long_len = LINE_LEN;
                else if (ph == 3 && line_no == 0)
                    long_len = LINE_LEN + 6;
                compose_line(long_len);
                foreach (line_buf[k])
                    offer('{line_buf[k], 2'd0, '0, '0});
                // sender waits mid-phase for the output side to empty
                if (ph == 4 && line_no == 0)
                    go_quiet();
                line_no++;
            end
        end

        go_quiet();
        $display("Run covered %0d requests over %0d lines; %0d results checked.",
                 n_requests, n_lines, n_checked);
        $display("Comment code swept through 0, 255, comma, blank and random; long lines, "
                 , "output hold-off and drains included.");
        if (mismatches == 0)
            $display("asm_line_tokenizer_unit: match");
        else
            $display("asm_line_tokenizer_unit: mismatch");
        $finish;
    end

    // Hard stop, well beyond the slowest legal run.
    initial begin : watchdog
        #(12 * 800000);
        $display("asm_line_tokenizer_unit: mismatch");
        $finish;
    end

endmodule
